/* hdl/fbc_pkg.sv */
// Shared constants, command types and mixing functions for the frame block cipher.
package fbc_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_KEYS   = 4;
    localparam int NUM_BYTES  = 16;
    localparam int KS_STEPS   = 32;
    localparam int BT_STEPS   = 24;
    localparam int STEP_W     = $clog2(KS_STEPS);

    localparam logic [WORD_W-1:0] DELTA        = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] DEC_SUM_INIT = DELTA * 32'd6;

    localparam logic [WORD_W-1:0] KEY_RESET [NUM_KEYS] =
        '{32'hA5F9_B21C, 32'hAB3F_9D12, 32'hC6F3_4E34, 32'hD72F_A378};
    localparam logic [WORD_W-1:0] SCRAMBLE_RESET = 32'h956F_6C77;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLE = 3'd4;

    typedef enum logic [2:0] {
        SUM_HOLD,
        SUM_DELTA,
        SUM_DEC_INIT,
        SUM_ADD,
        SUM_SUB
    } fbc_sum_op_t;

    typedef struct packed {
        logic        load;
        logic        ks_step;
        logic        ks_xor;
        logic        enc_step;
        logic        dec_step;
        logic        out_load;
        logic [1:0]  word_idx;
        fbc_sum_op_t sum_op;
    } fbc_cmd_t;

    typedef struct packed {
        logic decrypt;
    } fbc_status_t;

    function automatic logic [7:0] bmix8(input logic [7:0] y, input logic [7:0] z,
                                         input logic [7:0] s);
        logic [7:0] a;
        logic [7:0] b;
        a = (z >> 5) ^ (y << 2);
        b = (y >> 3) ^ (z << 4);
        return (a + b) ^ (s ^ y);
    endfunction

    function automatic logic [WORD_W-1:0] wmix(input logic [WORD_W-1:0] y,
                                               input logic [WORD_W-1:0] z,
                                               input logic [WORD_W-1:0] s,
                                               input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (s ^ y) + (k ^ z);
        return a ^ b;
    endfunction

endpackage

/* hdl/fbc_ctrl.sv */
// Sequencing controller: handshakes, step counting and datapath commands.
module fbc_ctrl
    import fbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  fbc_status_t status,
    output fbc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_KS,
        ST_XOR,
        ST_ENC,
        ST_DEC,
        ST_FIN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sum_op     = SUM_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                step_next  = '0;
                state_next = status.decrypt ? ST_DEC : ST_KS;
            end
            ST_KS:
            begin
                cmd.ks_step = 1'b1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg[3:0] == 4'hF && step_reg != STEP_W'(KS_STEPS - 1))
                begin
                    cmd.sum_op = SUM_ADD;
                end
                if (step_reg == STEP_W'(KS_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_XOR;
                end
            end
            ST_XOR:
            begin
                cmd.ks_xor = 1'b1;
                if (status.decrypt)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.sum_op = SUM_DELTA;
                    state_next = ST_ENC;
                end
            end
            ST_ENC:
            begin
                cmd.enc_step = 1'b1;
                cmd.word_idx = step_reg[1:0];
                step_next    = step_reg + STEP_W'(1);
                if (step_reg[1:0] == 2'd3)
                begin
                    cmd.sum_op = SUM_ADD;
                end
                if (step_reg == STEP_W'(BT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end
            end
            ST_DEC:
            begin
                cmd.dec_step = 1'b1;
                cmd.word_idx = ~step_reg[1:0];
                step_next    = step_reg + STEP_W'(1);
                if (step_reg[1:0] == 2'd3)
                begin
                    cmd.sum_op = SUM_SUB;
                end
                if (step_reg == STEP_W'(BT_STEPS - 1))
                begin
                    cmd.sum_op = SUM_DELTA;
                    step_next  = '0;
                    state_next = ST_KS;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/fbc_dp.sv */
// Datapath: configuration registers, byte keystream mixer, word cipher and output register.
module fbc_dp
    import fbc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WORD_W-1:0]           cfg_data,
    input  logic                        in_cmd,
    input  logic [WORD_W-1:0]           in_utc,
    input  logic [5:0][WORD_W-1:0]      in_words,
    input  fbc_cmd_t                    cmd,
    output fbc_status_t                 status,
    output logic [5:0][WORD_W-1:0]      out_words
);

    logic [WORD_W-1:0] key_reg [NUM_KEYS];
    logic [WORD_W-1:0] scramble_reg;

    logic              decrypt_reg;
    logic [WORD_W-1:0] w0_reg;
    logic [WORD_W-1:0] w1_reg;
    logic [WORD_W-1:0] v_reg [4];
    logic [WORD_W-1:0] v_next [4];
    logic [7:0]        b_reg [NUM_BYTES];
    logic [7:0]        b_next [NUM_BYTES];
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [5:0][WORD_W-1:0] out_reg;

    logic [4*WORD_W-1:0] seed;
    logic [7:0]          byte_new;
    logic [WORD_W-1:0]   round_key;
    logic [WORD_W-1:0]   enc_new;
    logic [WORD_W-1:0]   dec_new;

    assign status.decrypt = decrypt_reg;
    assign out_words      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_reg[i] <= KEY_RESET[i];
            end
            scramble_reg <= SCRAMBLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_0:    key_reg[0]   <= cfg_data;
                REG_KEY_1:    key_reg[1]   <= cfg_data;
                REG_KEY_2:    key_reg[2]   <= cfg_data;
                REG_KEY_3:    key_reg[3]   <= cfg_data;
                REG_SCRAMBLE: scramble_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign seed      = {scramble_reg, in_utc >> 4, in_words[1], in_words[0]};
    assign byte_new  = b_reg[0] + bmix8(b_reg[1], b_reg[NUM_BYTES-1], sum_reg[7:0]);
    assign round_key = key_reg[cmd.word_idx ^ sum_reg[3:2]];
    assign enc_new   = v_reg[0] + wmix(v_reg[1], v_reg[3], sum_reg, round_key);
    assign dec_new   = v_reg[3] - wmix(v_reg[0], v_reg[2], sum_reg, round_key);

    always_comb
    begin
        b_next   = b_reg;
        v_next   = v_reg;
        sum_next = sum_reg;
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_BYTES; i++)
            begin
                b_next[i] = seed[8*i +: 8];
            end
            for (int i = 0; i < 4; i++)
            begin
                v_next[i] = in_words[i+2];
            end
        end
        else if (cmd.ks_step)
        begin
            for (int i = 0; i < NUM_BYTES - 1; i++)
            begin
                b_next[i] = b_reg[i+1];
            end
            b_next[NUM_BYTES-1] = byte_new;
        end
        else if (cmd.ks_xor)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_next[i] = v_reg[i] ^ {b_reg[4*i+3], b_reg[4*i+2], b_reg[4*i+1], b_reg[4*i]};
            end
        end
        else if (cmd.enc_step)
        begin
            v_next[0] = v_reg[1];
            v_next[1] = v_reg[2];
            v_next[2] = v_reg[3];
            v_next[3] = enc_new;
        end
        else if (cmd.dec_step)
        begin
            v_next[0] = dec_new;
            v_next[1] = v_reg[0];
            v_next[2] = v_reg[1];
            v_next[3] = v_reg[2];
        end

        if (cmd.load)
        begin
            sum_next = in_cmd ? DEC_SUM_INIT : DELTA;
        end
        else
        begin
            case (cmd.sum_op)
                SUM_HOLD:     sum_next = sum_reg;
                SUM_DELTA:    sum_next = DELTA;
                SUM_DEC_INIT: sum_next = DEC_SUM_INIT;
                SUM_ADD:      sum_next = sum_reg + DELTA;
                SUM_SUB:      sum_next = sum_reg - DELTA;
                default:      sum_next = sum_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        v_reg   <= v_next;
        sum_reg <= sum_next;
        if (cmd.load)
        begin
            decrypt_reg <= in_cmd;
            w0_reg      <= in_words[0];
            w1_reg      <= in_words[1];
        end
        if (cmd.out_load)
        begin
            out_reg <= {v_reg[3], v_reg[2], v_reg[1], v_reg[0], w1_reg, w0_reg};
        end
    end

endmodule

/* hdl/frame_block_cipher.sv */
// Top level of the frame block cipher: controller, datapath and checks.
//
// Input channel: in_valid/in_ready carry one 24-byte frame word (six 32-bit
// words, cmd and utc_seconds). cmd 0 encrypts, 1 decrypts. Words 0 and 1
// pass straight through; words 2 to 5 are keystream-XORed and block-ciphered.
// Output channel: out_valid/out_ready carry the processed frame.
// The block works on one frame at a time: 32 byte-mixer steps, an XOR
// step and 24 word-cipher steps (word steps first when decrypting) run one
// per cycle through a single shared byte unit and an encrypt and a decrypt
// word unit; a new frame is taken only once the last one has been moved
// into the output register.
// The result sits in an output register; a stalled receiver does not stop
// the next frame from being taken, only its final transfer into the output
// register waits until the previous result has gone.
// Configuration: cfg_we writes cfg_data to register cfg_index (0..3 cipher
// key words, 4 scramble key); write only while the block is idle.
// Reset clears the controller and loads the default keys; no frame is held.
module frame_block_cipher
    import fbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [WORD_W-1:0]    utc_seconds,
    input  logic [WORD_W-1:0]    in_word_0,
    input  logic [WORD_W-1:0]    in_word_1,
    input  logic [WORD_W-1:0]    in_word_2,
    input  logic [WORD_W-1:0]    in_word_3,
    input  logic [WORD_W-1:0]    in_word_4,
    input  logic [WORD_W-1:0]    in_word_5,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    out_word_0,
    output logic [WORD_W-1:0]    out_word_1,
    output logic [WORD_W-1:0]    out_word_2,
    output logic [WORD_W-1:0]    out_word_3,
    output logic [WORD_W-1:0]    out_word_4,
    output logic [WORD_W-1:0]    out_word_5
);

    fbc_cmd_t               dp_cmd;
    fbc_status_t            dp_status;
    logic [5:0][WORD_W-1:0] in_words;
    logic [5:0][WORD_W-1:0] out_words;

    assign in_words = {in_word_5, in_word_4, in_word_3, in_word_2, in_word_1, in_word_0};

    fbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    fbc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (cmd),
        .in_utc    (utc_seconds),
        .in_words  (in_words),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_words (out_words)
    );

    assign out_word_0 = out_words[0];
    assign out_word_1 = out_words[1];
    assign out_word_2 = out_words[2];
    assign out_word_3 = out_words[3];
    assign out_word_4 = out_words[4];
    assign out_word_5 = out_words[5];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a frame is in progress");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result presented while the controller is still busy");

    a_one_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.load, dp_cmd.ks_step, dp_cmd.ks_xor, dp_cmd.enc_step,
                  dp_cmd.dec_step, dp_cmd.out_load}))
        else $error("more than one datapath operation issued in a cycle");

endmodule
